// ===== rtl/lslf_pkg.sv =====
`timescale 1ns / 1ps
package lslf_pkg;

  localparam int NUM_POINTS_DEF = 10;

  localparam int X_W     = 8;
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 40;

  localparam int SX_W    = 16;
  localparam int SXX_W   = 22;
  localparam int SXY_W   = 23;

  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;

  localparam int FRAC_W  = 16;
  localparam int DEN_W   = 27;
  localparam int NUM_W   = 52;
  localparam int QUO_W   = NUM_W + 1;

  localparam logic signed [QUO_W-1:0] SLOPE_HI = 53'sd2147483647;
  localparam logic signed [QUO_W-1:0] SLOPE_LO = -53'sd2147483648;
  localparam logic signed [QUO_W-1:0] ICPT_HI  = 53'sd549755813887;
  localparam logic signed [QUO_W-1:0] ICPT_LO  = -53'sd549755813888;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] numer;
    logic        [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/least_squares_line_fit.sv =====
`timescale 1ns / 1ps
// Least-squares line fit over sets of NUM_POINTS points.
// Input channel (in_valid/in_ready): one request per point, x_value and
// y_value as signed bytes. A point is taken in one cycle while the block
// accumulates. The last point of a set starts the fit; in_ready stays low
// until the fit is done.
// Output channel (out_valid/out_ready): one request per set with slope
// (Q16.16), intercept (Q24.16), both truncated toward zero and saturated,
// and degenerate (all x equal; slope and intercept then zero).
// After the last point, the fit forms its products on the shared 24x24
// multiplier, then runs two divides on the shared radix-4 divider and a
// load step into the output register; a degenerate set skips the divides.
// The result sits in an output register: the next set is accumulated while
// it waits. If the receiver still stalls when the next fit ends, the block
// holds that fit and stays not ready until the output register frees.
// Reset (rst, synchronous) clears the sums, the point count and out_valid.
module least_squares_line_fit #(
  parameter int NUM_POINTS = lslf_pkg::NUM_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lslf_pkg::X_W-1:0]     x_value,
  input  logic signed [lslf_pkg::X_W-1:0]     y_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lslf_pkg::SLOPE_W-1:0] slope,
  output logic signed [lslf_pkg::ICPT_W-1:0]  intercept,
  output logic                                degenerate
);
  import lslf_pkg::*;

  localparam int CNT_W = $clog2(NUM_POINTS);

  typedef enum logic [2:0] {S_ACC, S_FIT, S_DIV_S, S_DIV_I, S_LOAD} state_t;

  state_t state;
  logic [CNT_W-1:0] point_count;
  logic [2:0]       step;

  logic signed [SX_W-1:0]  sum_x;
  logic signed [SX_W-1:0]  sum_y;
  logic        [SXX_W-1:0] sum_xx;
  logic signed [SXY_W-1:0] sum_xy;

  logic signed [PROD_W-1:0] acc_a;
  logic        [DEN_W-1:0]  den;
  logic signed [NUM_W-1:0]  num_s;
  logic signed [NUM_W-1:0]  num_i;
  logic                     degen;

  logic signed [SLOPE_W-1:0] res_slope;
  logic signed [ICPT_W-1:0]  res_icpt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] diff;
  logic signed [NUM_W-1:0]  diff_scaled;
  logic signed [2*X_W-1:0]  xx;
  logic signed [2*X_W-1:0]  xy;
  logic signed [SLOPE_W-1:0] quot_slope;
  logic signed [ICPT_W-1:0]  quot_icpt;
  logic                      out_load;

  assign in_ready = (state == S_ACC);
  assign xx = x_value * x_value;
  assign xy = x_value * y_value;
  assign out_load = (state == S_LOAD) && (!out_valid || out_ready);

  always_comb begin
    case (step)
      3'd0:    begin mul_a = $signed(MUL_W'(NUM_POINTS)); mul_b = $signed({2'b0, sum_xx}); end
      3'd1:    begin mul_a = MUL_W'(sum_x);               mul_b = MUL_W'(sum_x);          end
      3'd2:    begin mul_a = $signed(MUL_W'(NUM_POINTS)); mul_b = MUL_W'(sum_xy);         end
      3'd3:    begin mul_a = MUL_W'(sum_x);               mul_b = MUL_W'(sum_y);          end
      3'd4:    begin mul_a = $signed({2'b0, sum_xx});     mul_b = MUL_W'(sum_y);          end
      3'd5:    begin mul_a = MUL_W'(sum_x);               mul_b = MUL_W'(sum_xy);         end
      default: begin mul_a = '0;                          mul_b = '0;                     end
    endcase
  end

  lslf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  lslf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign diff        = acc_a - prod;
  assign diff_scaled = {diff[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

  always_comb begin
    if (div_rsp.quot > SLOPE_HI) begin
      quot_slope = SLOPE_HI[SLOPE_W-1:0];
    end else if (div_rsp.quot < SLOPE_LO) begin
      quot_slope = SLOPE_LO[SLOPE_W-1:0];
    end else begin
      quot_slope = div_rsp.quot[SLOPE_W-1:0];
    end
    if (div_rsp.quot > ICPT_HI) begin
      quot_icpt = ICPT_HI[ICPT_W-1:0];
    end else if (div_rsp.quot < ICPT_LO) begin
      quot_icpt = ICPT_LO[ICPT_W-1:0];
    end else begin
      quot_icpt = div_rsp.quot[ICPT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_ACC;
      point_count   <= '0;
      step          <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_xy        <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= ((state == S_FIT) && (step == 3'd6) && !degen) ||
                       ((state == S_DIV_S) && div_rsp.done);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_ACC: begin
          if (in_valid) begin
            sum_x  <= sum_x + SX_W'(x_value);
            sum_y  <= sum_y + SX_W'(y_value);
            sum_xx <= sum_xx + SXX_W'($unsigned(xx));
            sum_xy <= sum_xy + SXY_W'(xy);
            if (point_count == CNT_W'(NUM_POINTS - 1)) begin
              point_count <= '0;
              step        <= '0;
              state       <= S_FIT;
            end else begin
              point_count <= point_count + CNT_W'(1);
            end
          end
        end
        S_FIT: begin
          step <= (step == 3'd6) ? 3'd0 : step + 3'd1;
          case (step) inside
            3'd1, 3'd3, 3'd5: acc_a <= prod;
            3'd2: begin
              den   <= diff[DEN_W-1:0];
              degen <= (diff <= 0);
            end
            3'd4: num_s <= diff_scaled;
            3'd6: begin
              num_i  <= diff_scaled;
              sum_x  <= '0;
              sum_y  <= '0;
              sum_xx <= '0;
              sum_xy <= '0;
              if (degen) begin
                res_slope <= '0;
                res_icpt  <= '0;
                state     <= S_LOAD;
              end else begin
                div_req.numer <= num_s;
                div_req.denom <= den;
                state         <= S_DIV_S;
              end
            end
            default: ;
          endcase
        end
        S_DIV_S: begin
          if (div_rsp.done) begin
            res_slope     <= quot_slope;
            div_req.numer <= num_i;
            state         <= S_DIV_I;
          end
        end
        S_DIV_I: begin
          if (div_rsp.done) begin
            res_icpt <= quot_icpt;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_load) begin
            slope      <= res_slope;
            intercept  <= res_icpt;
            degenerate <= degen;
            state      <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> slope == '0 && intercept == '0)
    else $error("degenerate result not zero");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV_S || state == S_DIV_I)
    else $error("divide result outside divide phase");

  a_last_point: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && point_count == CNT_W'(NUM_POINTS - 1)
      |=> state == S_FIT && !in_ready)
    else $error("last point did not start fit");

endmodule

// ===== rtl/lslf_mul.sv =====
`timescale 1ns / 1ps
module lslf_mul (
  input  logic                               clk,
  input  logic signed [lslf_pkg::MUL_W-1:0]  a,
  input  logic signed [lslf_pkg::MUL_W-1:0]  b,
  output logic signed [lslf_pkg::PROD_W-1:0] p
);
  import lslf_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/lslf_div.sv =====
`timescale 1ns / 1ps
module lslf_div (
  input  logic                clk,
  input  logic                rst,
  input  lslf_pkg::div_req_t  req,
  output lslf_pkg::div_rsp_t  rsp
);
  import lslf_pkg::*;

  localparam int ITER  = NUM_W / 2;
  localparam int CNT_W = $clog2(ITER);
  localparam int REM_W = DEN_W + 1;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] den;
  logic             neg;

  logic [REM_W-1:0] rem_next;
  logic [NUM_W-1:0] q_next;
  logic [NUM_W-1:0] mag;

  // two restoring steps per cycle
  always_comb begin
    rem_next = rem;
    q_next   = q;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[REM_W-2:0], q_next[NUM_W-1]};
      q_next   = {q_next[NUM_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next  = rem_next - {1'b0, den};
        q_next[0] = 1'b1;
      end
    end
  end

  assign mag = req.numer[NUM_W-1] ? NUM_W'(-req.numer) : NUM_W'(req.numer);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= mag;
        den  <= req.denom;
        neg  <= req.numer[NUM_W-1];
      end else if (busy) begin
        rem <= rem_next;
        q   <= q_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divide started while busy");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start && cnt == CNT_W'(ITER - 1) |=> done && !busy)
    else $error("divide did not finish on last step");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held more than one cycle");

endmodule
